FILE: sv/gmnl_pkg.sv
// shared types and constants of the grid mesh neighbor list core
package gmnl_pkg;

    localparam int unsigned VertW = 20;
    localparam int unsigned SlotW = 23;
    localparam int unsigned ColW  = 11;
    localparam int unsigned RowW  = 11;
    localparam int unsigned VcntW = 21;
    localparam int unsigned CfgW  = 21;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned MaskW = 6;
    localparam int unsigned KW    = 3;

    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    localparam logic [CfgIdxW-1:0] REG_COLS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ROWS = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_VCNT = 2'd2;

    localparam logic [ColW-1:0]  COLS_MIN = 11'd2;
    localparam logic [ColW-1:0]  COLS_MAX = 11'd1024;
    localparam logic [RowW-1:0]  ROWS_MIN = 11'd2;
    localparam logic [RowW-1:0]  ROWS_MAX = 11'd1024;
    localparam logic [VcntW-1:0] VCNT_MIN = 21'd4;

    // neighbor positions in emission order
    localparam logic [KW-1:0] NB_UL = 3'd0;
    localparam logic [KW-1:0] NB_U  = 3'd1;
    localparam logic [KW-1:0] NB_L  = 3'd2;
    localparam logic [KW-1:0] NB_R  = 3'd3;
    localparam logic [KW-1:0] NB_D  = 3'd4;
    localparam logic [KW-1:0] NB_DR = 3'd5;

    typedef struct packed {
        logic [VertW-1:0] vertex;
        logic [ColW-1:0]  cols;
        logic [SlotW-1:0] offset;
        logic [MaskW-1:0] mask;
    } t_job;

endpackage

FILE: sv/gmnl_ifs.sv
// valid/ready channel interfaces for items and results
interface gmnl_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface gmnl_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] vertex_index;
    logic [19:0] neighbor_index;
    logic [22:0] slot;
    logic        last_of_vertex;

    modport source (output valid, output vertex_index, output neighbor_index,
                    output slot, output last_of_vertex, input ready);
    modport sink (input valid, input vertex_index, input neighbor_index,
                  input slot, input last_of_vertex, output ready);
endinterface

FILE: sv/gmnl_front.sv
// front end: config registers, vertex counters and neighbor classification
module gmnl_front
    import gmnl_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 1048576
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gmnl_in_if.sink            i_item,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_wdata,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    localparam logic [31:0] MaxV = 32'(MAX_VERTICES);

    logic [ColW-1:0]  r_cols;
    logic [RowW-1:0]  r_rows;
    logic [VcntW-1:0] r_vcnt;

    logic [VcntW-1:0] r_v;
    logic [RowW-1:0]  r_row;
    logic [ColW-2:0]  r_col;
    logic [SlotW-1:0] r_off;

    logic [ColW-1:0]  c_cols;
    logic [RowW-1:0]  c_rows;
    logic [VcntW-1:0] c_vcnt;
    logic             clr;
    logic [VcntW-1:0] v;
    logic [RowW-1:0]  row;
    logic [ColW-2:0]  col;
    logic [SlotW-1:0] off;
    logic             in_grid;
    logic             has_up;
    logic             has_down;
    logic             has_left;
    logic             has_right;
    logic [MaskW-1:0] mask;
    logic [KW-1:0]    n;
    logic [VcntW-1:0] v_inc;
    logic             wrap;
    logic             col_end;
    logic             accept;
    logic             cfg_hit;

    logic [VcntW-1:0] n_v;
    logic [RowW-1:0]  n_row;
    logic [ColW-2:0]  n_col;
    logic [SlotW-1:0] n_off;

    always_comb begin
        if (r_cols < COLS_MIN) begin
            c_cols = COLS_MIN;
        end else if (r_cols > COLS_MAX) begin
            c_cols = COLS_MAX;
        end else begin
            c_cols = r_cols;
        end
        if (r_rows < ROWS_MIN) begin
            c_rows = ROWS_MIN;
        end else if (r_rows > ROWS_MAX) begin
            c_rows = ROWS_MAX;
        end else begin
            c_rows = r_rows;
        end
        if (r_vcnt < VCNT_MIN) begin
            c_vcnt = VCNT_MIN;
        end else if (32'(r_vcnt) > MaxV) begin
            c_vcnt = MaxV[VcntW-1:0];
        end else begin
            c_vcnt = r_vcnt;
        end
    end

    assign clr = i_item.restart || (r_v >= c_vcnt);
    assign v   = clr ? '0 : r_v;
    assign row = clr ? '0 : r_row;
    assign col = clr ? '0 : r_col;
    assign off = clr ? '0 : r_off;

    assign in_grid   = row < c_rows;
    assign has_up    = row != '0;
    assign has_down  = (row + RowW'(1)) < c_rows;
    assign has_left  = col != '0;
    assign has_right = ({1'b0, col} + ColW'(1)) < c_cols;

    always_comb begin
        mask        = '0;
        mask[NB_UL] = in_grid && has_up && has_left;
        mask[NB_U]  = in_grid && has_up;
        mask[NB_L]  = in_grid && has_left;
        mask[NB_R]  = in_grid && has_right;
        mask[NB_D]  = in_grid && has_down;
        mask[NB_DR] = in_grid && has_down && has_right;
    end

    assign n       = KW'($countones(mask));
    assign v_inc   = v + VcntW'(1);
    assign wrap    = v_inc >= c_vcnt;
    assign col_end = ({1'b0, col} + ColW'(1)) >= c_cols;

    always_comb begin
        n_off = off + SlotW'(n);
        n_v   = v_inc;
        n_row = row;
        n_col = col + 1'b1;
        if (wrap) begin
            n_v   = '0;
            n_row = '0;
            n_col = '0;
            n_off = '0;
        end else if (col_end) begin
            n_col = '0;
            if (in_grid) begin
                n_row = row + RowW'(1);
            end
        end
    end

    assign i_item.ready = !i_full;
    assign accept       = i_item.valid && !i_full;
    assign o_push       = accept && (mask != '0);

    assign o_job.vertex = v[VertW-1:0];
    assign o_job.cols   = c_cols;
    assign o_job.offset = off;
    assign o_job.mask   = mask;

    assign cfg_hit = i_cfg_we && (i_cfg_index == REG_COLS || i_cfg_index == REG_ROWS ||
                                  i_cfg_index == REG_VCNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_MIN;
            r_rows <= ROWS_MIN;
            r_vcnt <= VCNT_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COLS: r_cols <= i_cfg_wdata[ColW-1:0];
                REG_ROWS: r_rows <= i_cfg_wdata[RowW-1:0];
                REG_VCNT: r_vcnt <= i_cfg_wdata[VcntW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_v   <= '0;
            r_row <= '0;
            r_col <= '0;
            r_off <= '0;
        end else if (accept) begin
            r_v   <= n_v;
            r_row <= n_row;
            r_col <= n_col;
            r_off <= n_off;
        end
    end

endmodule

FILE: sv/gmnl_queue.sv
// two-entry job queue between front and back
module gmnl_queue
    import gmnl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QCntW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == QCntW'(QDepth);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPtrW'(QDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPtrW'(QDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: sv/gmnl_back.sv
// back end: walks a job's neighbor mask and emits one result per unstalled cycle
module gmnl_back
    import gmnl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    gmnl_out_if.source  o_result
);

    logic             r_busy;
    t_job             r_job;
    logic [MaskW-1:0] r_rem;
    logic [KW-1:0]    r_k;
    logic             r_ovalid;
    logic [VertW-1:0] r_vert;
    logic [VertW-1:0] r_nb;
    logic [SlotW-1:0] r_slot;
    logic             r_last;

    logic             out_free;
    logic             emit;
    logic             load;
    logic [KW-1:0]    sel;
    logic             found;
    logic [MaskW-1:0] rem_clr;
    logic             last;
    logic [VertW-1:0] cols_ext;
    logic [VertW-1:0] addend;
    logic             cin;
    logic [VertW-1:0] nb;

    always_comb begin
        sel   = NB_UL;
        found = 1'b0;
        for (int i = 0; i < MaskW; i++) begin
            if (!found && r_rem[i]) begin
                sel   = KW'(i);
                found = 1'b1;
            end
        end
    end

    assign rem_clr  = r_rem & (r_rem - MaskW'(1));
    assign last     = rem_clr == '0;
    assign cols_ext = VertW'(r_job.cols);

    always_comb begin
        unique case (sel)
            NB_UL: begin addend = ~cols_ext; cin = 1'b0; end
            NB_U:  begin addend = ~cols_ext; cin = 1'b1; end
            NB_L:  begin addend = '1;        cin = 1'b0; end
            NB_R:  begin addend = '0;        cin = 1'b1; end
            NB_D:  begin addend = cols_ext;  cin = 1'b0; end
            NB_DR: begin addend = cols_ext;  cin = 1'b1; end
            default: begin addend = '0; cin = 1'b0; end
        endcase
    end

    assign nb = r_job.vertex + addend + VertW'(cin);

    assign out_free = !r_ovalid || o_result.ready;
    assign emit     = r_busy && out_free;
    assign load     = !r_busy || (emit && last);
    assign o_pop    = load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_rem <= i_job.mask;
            r_k   <= '0;
        end else if (emit) begin
            r_rem <= rem_clr;
            r_k   <= r_k + 1'b1;
        end
        if (emit) begin
            r_vert <= r_job.vertex;
            r_nb   <= nb;
            r_slot <= r_job.offset + SlotW'(r_k);
            r_last <= last;
        end
    end

    assign o_result.valid          = r_ovalid;
    assign o_result.vertex_index   = r_vert;
    assign o_result.neighbor_index = r_nb;
    assign o_result.slot           = r_slot;
    assign o_result.last_of_vertex = r_last;

endmodule

FILE: sv/grid_mesh_neighbor_list_core.sv
// top level of the grid mesh neighbor list core
//
//  channel   dir  handshake             payload
//  i_item    in   valid/ready           restart
//  o_result  out  valid/ready           vertex_index neighbor_index slot last_of_vertex
//  i_cfg_*   in   write enable only     index, data
//
// one vertex is accepted per cycle while the two-entry job queue has room
// results leave one per cycle while o_result is ready: 6 results per inner
// vertex, 4 per edge vertex, 2 or 3 per corner, none for a vertex beyond the last row
// the single result register and the back end mask walker set that rate
// synchronous active-low reset clears counters, queue and result register,
// and sets the registers to 2, 2 and 4
// a stalled result holds the back end; the front keeps taking items until the queue fills
module grid_mesh_neighbor_list_core
    import gmnl_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 1048576
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gmnl_in_if.sink            i_item,
    gmnl_out_if.source         o_result,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_wdata
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    gmnl_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    gmnl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    gmnl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

FILE: sv/gmnl_checker.sv
// port-level assertions for the grid mesh neighbor list core
module gmnl_checker
    import gmnl_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VertW-1:0] i_vertex_index,
    input logic [VertW-1:0] i_neighbor_index,
    input logic [SlotW-1:0] i_slot,
    input logic             i_last_of_vertex
);

    logic out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_vertex_index) &&
        $stable(i_neighbor_index) && $stable(i_slot) && $stable(i_last_of_vertex))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not idle after reset");

    a_same_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !i_last_of_vertex) ##1 i_out_valid |->
        i_vertex_index == $past(i_vertex_index))
        else $error("vertex changed before last neighbor");

    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !i_last_of_vertex) ##1 i_out_valid |->
        i_slot == SlotW'($past(i_slot) + 1'b1))
        else $error("slot did not advance by one");

endmodule

bind grid_mesh_neighbor_list_core gmnl_checker u_gmnl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_vertex_index   (o_result.vertex_index),
    .i_neighbor_index (o_result.neighbor_index),
    .i_slot           (o_result.slot),
    .i_last_of_vertex (o_result.last_of_vertex)
);
